// ===== hw/rtl/dvrt_pkg.sv =====
// Package for the distance-vector route table: operation codes, status codes,
// controller/datapath command and status structs. No dependencies.
package dvrt_pkg;

   localparam logic [2:0] OP_LOAD   = 3'd0;
   localparam logic [2:0] OP_TICK   = 3'd1;
   localparam logic [2:0] OP_COST   = 3'd2;
   localparam logic [2:0] OP_RECV   = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;

   localparam logic [1:0] ST_ADVERT  = 2'd0;
   localparam logic [1:0] ST_REACHED = 2'd1;
   localparam logic [1:0] ST_FORWARD = 2'd2;
   localparam logic [1:0] ST_DOWN    = 2'd3;

   localparam logic [1:0] CSR_MY_NODE  = 2'd0;
   localparam logic [1:0] CSR_INFINITY = 2'd1;
   localparam logic [1:0] CSR_DOWN     = 2'd2;

   localparam logic [4:0] UNDEF_HOP = 5'd16;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  node_a;
      logic [3:0]  node_b;
      logic [15:0] cost;
      logic [4:0]  advertised_hop;
      logic        direct_link;
      logic        vector_end;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [3:0]  entry_node;
      logic [4:0]  hop;
      logic [15:0] path_cost;
      logic [15:0] neighbour_mask;
      logic        final_res;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request
      logic execute;   // apply load/cost/recv/tick-increment
      logic age;       // timeout check of one entry
      logic emit;      // build one result into output register
      logic emit_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] operation;
      logic       out_full;
   } sts_type;

endpackage

// ===== hw/rtl/distance_vector_route_table.sv =====
// channel | dir | payload
// req     | in  | tdata: operation, node_a, node_b, cost, advertised_hop, direct_link, vector_end
// rsp     | out | tdata: status, entry_node, hop, path_cost, neighbour_mask; tuser kind; tlast
// csr     | in  | index (2b), data (16b)
// Load, cost change, received entry: capture in idle, execute, then back to idle.
// Lookup: execute, then emit into the output register, wait, and back to idle.
// Tick: execute, then aging of every entry (one entry a cycle), then one emit per
// entry and wait; output register stalls hold the emit sequence.
// Reset is synchronous and restores the table, the CSRs and the state registers; one item at a time.
// Top level: route table; depends on dvrt_pkg, dvrt_ctrl, dvrt_datapath.
module distance_vector_route_table #(
   parameter int unsigned NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] operation, [6:3] node_a, [10:7] node_b, [26:11] link_or_path_cost,
   // [31:27] advertised_hop
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,    // direct_link
   input  logic        req_tlast,    // vector_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [5:2] entry_node, [10:6] hop, [26:11] path_cost,
   // [42:27] neighbour_mask, rest zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser,    // kind
   output logic        rsp_tlast,    // final_res
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [3:0]  my_node_ff;
   logic [15:0] inf_ff;
   logic [7:0]  down_ff;
   dvrt_pkg::req_type req;
   dvrt_pkg::rsp_type rsp;
   dvrt_pkg::cmd_type cmd;
   dvrt_pkg::sts_type sts;
   logic [$clog2(NODES)-1:0] idx;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         my_node_ff <= '0;
         inf_ff <= 16'd16;
         down_ff <= 8'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            dvrt_pkg::CSR_MY_NODE:  my_node_ff <= csr_data[3:0];
            dvrt_pkg::CSR_INFINITY: inf_ff <= csr_data;
            dvrt_pkg::CSR_DOWN:     down_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req.operation = req_tdata[2:0];
   assign req.node_a = req_tdata[6:3];
   assign req.node_b = req_tdata[10:7];
   assign req.cost = req_tdata[26:11];
   assign req.advertised_hop = req_tdata[31:27];
   assign req.direct_link = req_tuser;
   assign req.vector_end = req_tlast;

   dvrt_ctrl #(.NODES(NODES)) u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sts(sts), .cmd(cmd), .idx(idx)
   );

   dvrt_datapath #(.NODES(NODES)) u_dp (
      .clock(clock), .reset(reset), .req(req), .cmd(cmd), .idx(idx),
      .my_node(my_node_ff), .infinity_cost(inf_ff), .down_ticks(down_ff),
      .sts(sts), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp)
   );

   assign rsp_tdata = {5'd0, rsp.neighbour_mask, rsp.path_cost, rsp.hop,
                       rsp.entry_node, rsp.status};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.final_res;
endmodule

// ===== hw/rtl/dvrt_ctrl.sv =====
// Controller for the route table: sequences one item at a time.
// Depends on dvrt_pkg.
module dvrt_ctrl #(
   parameter int unsigned NODES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  dvrt_pkg::sts_type   sts,
   output dvrt_pkg::cmd_type   cmd,
   output logic [$clog2(NODES)-1:0] idx
);
   localparam int unsigned IW = $clog2(NODES);
   localparam int unsigned EMIT = (NODES < 16) ? NODES : 16;
   localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);
   localparam logic [IW-1:0] LAST_EMIT = IW'(EMIT - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_AGE  = 5'b00100,
      S_EMIT = 5'b01000,
      S_WAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;

   assign req_tready = (state_ff == S_IDLE);
   assign idx = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            idx_in = '0;
            if (sts.operation == dvrt_pkg::OP_TICK) state_in = S_AGE;
            else if (sts.operation == dvrt_pkg::OP_LOOKUP) state_in = S_EMIT;
            else state_in = S_IDLE;
         end
         S_AGE: begin
            cmd.age = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_NODE) begin
               idx_in = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!sts.out_full) begin
               cmd.emit = 1'b1;
               if (sts.operation != dvrt_pkg::OP_TICK || idx_ff == LAST_EMIT) begin
                  cmd.emit_last = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end
endmodule

// ===== hw/rtl/dvrt_datapath.sv =====
// Datapath for the route table: table registers, relaxation, aging,
// output register. Depends on dvrt_pkg.
module dvrt_datapath #(
   parameter int unsigned NODES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dvrt_pkg::req_type   req,
   input  dvrt_pkg::cmd_type   cmd,
   input  logic [$clog2(NODES)-1:0] idx,
   input  logic [3:0]          my_node,
   input  logic [15:0]         infinity_cost,
   input  logic [7:0]          down_ticks,
   output dvrt_pkg::sts_type   sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dvrt_pkg::rsp_type   rsp
);
   localparam int unsigned IW = $clog2(NODES);

   dvrt_pkg::req_type r_ff;
   logic [4:0]  hop_ff   [NODES];
   logic [15:0] rcost_ff [NODES];
   logic [15:0] dcost_ff [NODES];
   logic [NODES-1:0] direct_ff, alive_ff, known_ff;
   logic [31:0] heard_ff [NODES];
   logic [31:0] tick_ff;
   logic [15:0] mask_ff;
   logic        full_ff;
   dvrt_pkg::rsp_type out_ff;

   logic a_ok, b_ok;
   logic [IW-1:0] ai, bi;
   logic [16:0] sum;
   logic [15:0] sat;
   logic [31:0] elapsed;
   logic [15:0] mask_next;
   logic        relax;
   logic [15:0] b_cost;

   assign a_ok = ({4'd0, r_ff.node_a} < 8'(NODES)) || (NODES > 16);
   assign b_ok = ({4'd0, r_ff.node_b} < 8'(NODES)) || (NODES > 16);
   assign ai = IW'(r_ff.node_a);
   assign bi = IW'(r_ff.node_b);
   assign sum = {1'b0, r_ff.cost} + {1'b0, dcost_ff[bi]};
   assign sat = (sum >= {1'b0, infinity_cost}) ? infinity_cost : sum[15:0];
   assign elapsed = tick_ff - heard_ff[idx];
   assign relax = known_ff[ai] && (({1'b0, rcost_ff[ai]} > sum &&
                  r_ff.advertised_hop != 5'(my_node)) ||
                  hop_ff[ai] == 5'(r_ff.node_b));
   // sender's own entry may just have been relaxed by this item
   assign b_cost = (relax && r_ff.node_a == r_ff.node_b) ? sat : rcost_ff[bi];

   always_comb begin
      mask_next = '0;
      for (int k = 0; k < NODES && k < 16; k++)
         if (direct_ff[k] && 4'(k) != my_node) mask_next[k] = 1'b1;
   end

   assign sts.operation = r_ff.operation;
   assign sts.out_full = full_ff && !rsp_ready;
   assign rsp_valid = full_ff;
   assign rsp = out_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) r_ff <= req;
      if (cmd.execute) mask_ff <= mask_next;
      if (cmd.age && alive_ff[idx] && elapsed >= {24'd0, down_ticks})
         rcost_ff[idx] <= infinity_cost;
      if (cmd.execute) begin
         unique case (r_ff.operation)
            dvrt_pkg::OP_LOAD: if (a_ok) begin
               if (r_ff.node_a == my_node) begin
                  hop_ff[ai] <= 5'(r_ff.node_a);
                  rcost_ff[ai] <= '0;
                  dcost_ff[ai] <= '0;
               end else if (r_ff.direct_link) begin
                  hop_ff[ai] <= 5'(r_ff.node_a);
                  rcost_ff[ai] <= r_ff.cost;
                  dcost_ff[ai] <= r_ff.cost;
                  heard_ff[ai] <= '0;
               end else begin
                  hop_ff[ai] <= dvrt_pkg::UNDEF_HOP;
                  rcost_ff[ai] <= infinity_cost;
                  dcost_ff[ai] <= infinity_cost;
               end
            end
            dvrt_pkg::OP_COST: begin
               if (b_ok && r_ff.node_b != my_node) begin
                  if (hop_ff[bi] == 5'(r_ff.node_b)) rcost_ff[bi] <= r_ff.cost;
                  if (direct_ff[bi]) dcost_ff[bi] <= r_ff.cost;
               end
               if (a_ok && r_ff.node_a != my_node) begin
                  if (hop_ff[ai] == 5'(r_ff.node_a)) rcost_ff[ai] <= r_ff.cost;
                  if (direct_ff[ai]) dcost_ff[ai] <= r_ff.cost;
               end
            end
            dvrt_pkg::OP_RECV: if (a_ok && b_ok) begin
               if (relax) begin
                  hop_ff[ai] <= 5'(r_ff.node_b);
                  rcost_ff[ai] <= sat;
               end
               // a vector end overrides the relaxed entry of the sender
               if (r_ff.vector_end) begin
                  if (!alive_ff[bi] && b_cost > dcost_ff[bi]) begin
                     rcost_ff[bi] <= dcost_ff[bi];
                     hop_ff[bi] <= 5'(r_ff.node_b);
                  end
                  heard_ff[bi] <= tick_ff;
               end
            end
            default: ;
         endcase
      end
      if (cmd.emit) begin
         out_ff.final_res <= cmd.emit_last;
         out_ff.entry_node <= (r_ff.operation == dvrt_pkg::OP_TICK) ? 4'(idx) : r_ff.node_a;
         if (r_ff.operation == dvrt_pkg::OP_TICK) begin
            out_ff.kind <= 1'b0;
            out_ff.status <= dvrt_pkg::ST_ADVERT;
            out_ff.hop <= hop_ff[idx];
            out_ff.path_cost <= rcost_ff[idx];
            out_ff.neighbour_mask <= mask_ff;
         end else begin
            out_ff.kind <= 1'b1;
            out_ff.neighbour_mask <= '0;
            out_ff.hop <= dvrt_pkg::UNDEF_HOP;
            out_ff.path_cost <= '0;
            if (r_ff.node_a == my_node) out_ff.status <= dvrt_pkg::ST_REACHED;
            else if (!a_ok || !known_ff[ai]) out_ff.status <= dvrt_pkg::ST_ADVERT;
            else if (hop_ff[ai] == dvrt_pkg::UNDEF_HOP) begin
               out_ff.status <= dvrt_pkg::ST_DOWN;
               out_ff.path_cost <= rcost_ff[ai];
            end else begin
               out_ff.status <= dvrt_pkg::ST_FORWARD;
               out_ff.hop <= hop_ff[ai];
               out_ff.path_cost <= rcost_ff[ai];
            end
         end
      end
      if (reset) begin
         for (int k = 0; k < NODES; k++) begin
            hop_ff[k] <= dvrt_pkg::UNDEF_HOP;
            rcost_ff[k] <= '1;
            dcost_ff[k] <= '1;
            heard_ff[k] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direct_ff <= '0;
         alive_ff <= '0;
         known_ff <= '0;
         tick_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         if (cmd.emit) full_ff <= 1'b1;
         else if (rsp_ready) full_ff <= 1'b0;
         if (cmd.age && alive_ff[idx] && elapsed >= {24'd0, down_ticks})
            alive_ff[idx] <= 1'b0;
         if (cmd.execute) begin
            if (r_ff.operation == dvrt_pkg::OP_TICK) tick_ff <= tick_ff + 32'd1;
            if (r_ff.operation == dvrt_pkg::OP_LOAD && a_ok) begin
               known_ff[ai] <= 1'b1;
               direct_ff[ai] <= (r_ff.node_a != my_node) && r_ff.direct_link;
               alive_ff[ai] <= (r_ff.node_a != my_node) && r_ff.direct_link;
            end
            if (r_ff.operation == dvrt_pkg::OP_RECV && a_ok && b_ok && r_ff.vector_end)
               alive_ff[bi] <= 1'b1;
         end
      end
   end
endmodule

// ===== verif/dvrt_checker.sv =====
`timescale 1ns / 1ps
// Route table checker: watches the csr, req and rsp channels, keeps its own copy of the
// table and compares every rsp item with the expected one. Depends on dvrt_pkg.
module dvrt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          errors,
   output int          pending
);

   logic [3:0]  my_node;
   logic [15:0] inf_cost;
   logic [7:0]  down_ticks;
   logic [4:0]  route_hop [16];
   logic [15:0] route_cost [16];
   logic [15:0] direct_cost [16];
   bit          is_direct [16];
   bit          alive [16];
   bit          known [16];
   logic [31:0] heard [16];
   logic [31:0] tick_count;

   dvrt_pkg::rsp_type route_q [$];

   assign pending = route_q.size();

   function automatic dvrt_pkg::rsp_type make_rsp(logic kind, logic [1:0] st,
                                                  logic [3:0] node, logic [4:0] hop,
                                                  logic [15:0] cost, logic [15:0] mask,
                                                  logic fin);
      dvrt_pkg::rsp_type r;
      r.kind = kind;
      r.status = st;
      r.entry_node = node;
      r.hop = hop;
      r.path_cost = cost;
      r.neighbour_mask = mask;
      r.final_res = fin;
      return r;
   endfunction

   task automatic clear_table();
      my_node = '0;
      inf_cost = 16'd16;
      down_ticks = 8'd3;
      tick_count = '0;
      for (int k = 0; k < 16; k++) begin
         route_hop[k] = dvrt_pkg::UNDEF_HOP;
         route_cost[k] = 16'hFFFF;
         direct_cost[k] = 16'hFFFF;
         is_direct[k] = 1'b0;
         alive[k] = 1'b0;
         known[k] = 1'b0;
         heard[k] = '0;
      end
   endtask

   task automatic change_end(logic [3:0] x, logic [15:0] cost);
      if (x != my_node) begin
         if (route_hop[x] == {1'b0, x}) route_cost[x] = cost;
         if (is_direct[x]) direct_cost[x] = cost;
      end
   endtask

   task automatic predict_route(logic [2:0] op, logic [3:0] a, logic [3:0] b,
                                logic [15:0] cost, logic [4:0] ahop, logic dl, logic ve);
      logic [16:0] sum;
      logic [15:0] mask;
      case (op)
         dvrt_pkg::OP_LOAD: begin
            known[a] = 1'b1;
            if (a == my_node) begin
               route_hop[a] = {1'b0, a};
               route_cost[a] = '0;
               direct_cost[a] = '0;
               is_direct[a] = 1'b0;
               alive[a] = 1'b0;
            end else if (dl) begin
               route_hop[a] = {1'b0, a};
               route_cost[a] = cost;
               direct_cost[a] = cost;
               is_direct[a] = 1'b1;
               alive[a] = 1'b1;
               heard[a] = '0;
            end else begin
               route_hop[a] = dvrt_pkg::UNDEF_HOP;
               route_cost[a] = inf_cost;
               direct_cost[a] = inf_cost;
               is_direct[a] = 1'b0;
               alive[a] = 1'b0;
            end
         end
         dvrt_pkg::OP_TICK: begin
            tick_count = tick_count + 32'd1;
            mask = '0;
            for (int k = 0; k < 16; k++) begin
               if (alive[k] && (tick_count - heard[k]) >= {24'd0, down_ticks}) begin
                  route_cost[k] = inf_cost;
                  alive[k] = 1'b0;
               end
            end
            for (int k = 0; k < 16; k++)
               if (is_direct[k] && 4'(k) != my_node) mask[k] = 1'b1;
            for (int k = 0; k < 16; k++)
               route_q.push_back(make_rsp(1'b0, dvrt_pkg::ST_ADVERT, 4'(k), route_hop[k],
                                          route_cost[k], mask, k == 15));
         end
         dvrt_pkg::OP_COST: begin
            change_end(b, cost);
            change_end(a, cost);
         end
         dvrt_pkg::OP_RECV: begin
            sum = {1'b0, cost} + {1'b0, direct_cost[b]};
            if (known[a]) begin
               if (({1'b0, route_cost[a]} > sum && ahop != {1'b0, my_node}) ||
                   route_hop[a] == {1'b0, b}) begin
                  route_hop[a] = {1'b0, b};
                  route_cost[a] = (sum >= {1'b0, inf_cost}) ? inf_cost : sum[15:0];
               end
            end
            if (ve) begin
               if (!alive[b] && route_cost[b] > direct_cost[b]) begin
                  route_cost[b] = direct_cost[b];
                  route_hop[b] = {1'b0, b};
               end
               heard[b] = tick_count;
               alive[b] = 1'b1;
            end
         end
         dvrt_pkg::OP_LOOKUP: begin
            if (a == my_node)
               route_q.push_back(make_rsp(1'b1, dvrt_pkg::ST_REACHED, a, dvrt_pkg::UNDEF_HOP,
                                          '0, '0, 1'b1));
            else if (!known[a])
               route_q.push_back(make_rsp(1'b1, dvrt_pkg::ST_ADVERT, a, dvrt_pkg::UNDEF_HOP,
                                          '0, '0, 1'b1));
            else if (route_hop[a] == dvrt_pkg::UNDEF_HOP)
               route_q.push_back(make_rsp(1'b1, dvrt_pkg::ST_DOWN, a, dvrt_pkg::UNDEF_HOP,
                                          route_cost[a], '0, 1'b1));
            else
               route_q.push_back(make_rsp(1'b1, dvrt_pkg::ST_FORWARD, a, route_hop[a],
                                          route_cost[a], '0, 1'b1));
         end
         default: ;  // unused codes are ignored
      endcase
   endtask

   always @(posedge clock) begin
      dvrt_pkg::rsp_type got, want;
      if (reset) begin
         clear_table();
         route_q.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dvrt_pkg::CSR_MY_NODE:  my_node = csr_data[3:0];
               dvrt_pkg::CSR_INFINITY: inf_cost = csr_data;
               dvrt_pkg::CSR_DOWN:     down_ticks = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_route(req_tdata[2:0], req_tdata[6:3], req_tdata[10:7], req_tdata[26:11],
                          req_tdata[31:27], req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = make_rsp(rsp_tuser, rsp_tdata[1:0], rsp_tdata[5:2], rsp_tdata[10:6],
                           rsp_tdata[26:11], rsp_tdata[42:27], rsp_tlast);
            if (route_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected rsp item: %p", got);
               errors <= errors + 1;
            end else begin
               want = route_q.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("rsp mismatch: expected %p, got %p", want, got);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top of the route table testbench: clock, reset, stimulus and verdict.
// Depends on dvrt_pkg, distance_vector_route_table and dvrt_checker.
module tb;

   localparam int LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready, req_tuser, req_tlast;
   logic [31:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tuser, rsp_tlast;
   logic [47:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   int          errors, pending;
   int          cycles;
   int          tx_idle, rx_idle;
   logic [3:0]  cur_node;

   distance_vector_route_table u_dut (.*);

   dvrt_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL distance_vector_route_table");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle);

   task automatic send_item(logic [2:0] op, logic [3:0] a, logic [3:0] b, logic [15:0] cost,
                            logic [4:0] ahop, logic dl, logic ve);
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ahop, cost, b, a, op};
      req_tuser <= dl;
      req_tlast <= ve;
      do @(posedge clock); while (!req_tready);
   endtask

   // let the table settle, then write one register
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [4:0] pick_ahop();
      int r;
      r = $urandom_range(99);
      if (r < 20) return {1'b0, cur_node};
      if (r < 30) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(0, 16));
   endfunction

   function automatic logic [15:0] pick_cost();
      if ($urandom_range(9) == 0) return 16'($urandom());
      return 16'($urandom_range(0, 20));
   endfunction

   task automatic load_table();
      for (int k = 0; k < 16; k++)
         send_item(dvrt_pkg::OP_LOAD, 4'(k), 4'($urandom), pick_cost(), 5'($urandom),
                   1'($urandom_range(1)), 1'($urandom));
   endtask

   task automatic random_items(int n);
      int r, len;
      logic [3:0] nb;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 10)
            send_item(dvrt_pkg::OP_TICK, 4'($urandom), 4'($urandom), 16'($urandom),
                      5'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 22)
            send_item(dvrt_pkg::OP_LOOKUP, 4'($urandom), 4'($urandom), 16'($urandom),
                      5'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 30)
            send_item(dvrt_pkg::OP_COST, 4'($urandom), 4'($urandom), pick_cost(),
                      5'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 35)
            send_item(dvrt_pkg::OP_LOAD, 4'($urandom), 4'($urandom), pick_cost(),
                      5'($urandom), 1'($urandom_range(1)), 1'($urandom));
         else if (r < 38)
            send_item(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), 16'($urandom),
                      5'($urandom), 1'($urandom), 1'($urandom));
         else begin
            // one advertisement from a neighbour, vector end on its last entry
            nb = 4'($urandom);
            len = $urandom_range(1, 4);
            for (int j = 0; j < len; j++)
               send_item(dvrt_pkg::OP_RECV, 4'($urandom), nb, pick_cost(), pick_ahop(),
                         1'($urandom), j == len - 1 || $urandom_range(19) == 0);
         end
      end
   endtask

   task automatic run_phase(logic [3:0] me, logic [15:0] inf, logic [7:0] down, int n);
      write_reg(dvrt_pkg::CSR_MY_NODE, {12'd0, me});
      write_reg(dvrt_pkg::CSR_INFINITY, inf);
      write_reg(dvrt_pkg::CSR_DOWN, {8'd0, down});
      cur_node = me;
      load_table();
      random_items(n);
   endtask

   initial begin
      tx_idle = 25;
      rx_idle = 52;
      cur_node = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unknown and own lookups, unused codes, then a small topology
      send_item(dvrt_pkg::OP_LOOKUP, 4'd3, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_LOOKUP, 4'd0, 4'd15, 16'hFFFF, 5'd31, 1'b1, 1'b1);
      send_item(3'd5, 4'd15, 4'd15, 16'hFFFF, 5'd31, 1'b1, 1'b1);
      send_item(3'd7, 4'd0, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_TICK, 4'd0, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_LOAD, 4'd0, 4'd0, 16'd9, 5'd0, 1'b1, 1'b0);
      send_item(dvrt_pkg::OP_LOAD, 4'd1, 4'd0, 16'd1, 5'd0, 1'b1, 1'b0);
      send_item(dvrt_pkg::OP_LOAD, 4'd2, 4'd0, 16'd4, 5'd0, 1'b1, 1'b0);
      send_item(dvrt_pkg::OP_LOAD, 4'd15, 4'd0, 16'hFFFF, 5'd0, 1'b1, 1'b0);
      send_item(dvrt_pkg::OP_LOAD, 4'd7, 4'd0, 16'd3, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_LOAD, 4'd9, 4'd0, 16'd3, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_RECV, 4'd7, 4'd1, 16'd2, 5'd16, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_RECV, 4'd9, 4'd2, 16'd1, 5'd0, 1'b0, 1'b1);     // split horizon
      send_item(dvrt_pkg::OP_RECV, 4'd5, 4'd1, 16'd1, 5'd3, 1'b0, 1'b1);     // never loaded
      send_item(dvrt_pkg::OP_RECV, 4'd7, 4'd1, 16'hFFFF, 5'd20, 1'b0, 1'b1); // forced
      send_item(dvrt_pkg::OP_LOOKUP, 4'd7, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_COST, 4'd1, 4'd2, 16'd7, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_COST, 4'd0, 4'd0, 16'd5, 5'd0, 1'b0, 1'b0);     // own node
      send_item(dvrt_pkg::OP_TICK, 4'd0, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_TICK, 4'd0, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_TICK, 4'd0, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);     // links time out
      send_item(dvrt_pkg::OP_LOOKUP, 4'd9, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_RECV, 4'd2, 4'd2, 16'd0, 5'd16, 1'b0, 1'b1);    // link revives
      send_item(dvrt_pkg::OP_LOOKUP, 4'd2, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);
      send_item(dvrt_pkg::OP_TICK, 4'd0, 4'd0, 16'd0, 5'd0, 1'b0, 1'b0);

      random_items(10);
      run_phase(4'd15, 16'hFFFF, 8'd255, 10);
      tx_idle = 52;
      rx_idle = 25;
      run_phase(4'd5, 16'd1, 8'd1, 10);
      run_phase(4'd9, 16'd200, 8'd2, 10);
      tx_idle = 0;
      rx_idle = 0;
      run_phase(4'd3, 16'd30, 8'd4, 10);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("PASS distance_vector_route_table");
      else
         $display("FAIL distance_vector_route_table");
      $finish;
   end

endmodule

// ===== distance_vector_route_table.f =====
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_ctrl.sv
hw/rtl/dvrt_datapath.sv
hw/rtl/distance_vector_route_table.sv
verif/dvrt_checker.sv
verif/tb.sv
